FILE: src/ps2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2q_pkg
// Shared constants, codes, state encoding and ring helpers for the
// PS/2 device-side send queue.
// ----------------------------------------------------------------------------
package ps2q_pkg;

    localparam int SLOTS     = 16;
    localparam int MSG_BYTES = 8;

    localparam int ID_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int LEN_W     = $clog2(MSG_BYTES + 1);
    localparam int RAM_DEPTH = SLOTS * MSG_BYTES;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    localparam logic [9:0] LINE_DONE = 10'h3FF;
    localparam logic [9:0] LINE_FAIL = 10'h3C0;
    localparam logic [9:0] LINE_NONE = 10'h000;

    typedef enum logic [2:0] {
        FUNC_NORMAL = 3'd0,
        FUNC_PRIO   = 3'd1,
        FUNC_CLEAR  = 3'd2,
        FUNC_RESUME = 3'd3,
        FUNC_LOOP   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_RX   = 2'd1,
        KIND_STAT = 2'd2
    } kind_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_BYTE  = 7'b0000010,
        ST_STAT  = 7'b0000100,
        ST_CLEAR = 7'b0001000,
        ST_LOOP  = 7'b0010000,
        ST_RD    = 7'b0100000,
        ST_TX    = 7'b1000000
    } state_t;

    // ring pointer plus count, wrapped at SLOTS (n never exceeds SLOTS)
    function automatic logic [ID_W-1:0] ring_add(input logic [ID_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - ID_W){1'b0}}, p} + {1'b0, n};
        if (s >= (CNT_W + 1)'(SLOTS))
            s = s - (CNT_W + 1)'(SLOTS);
        return s[ID_W-1:0];
    endfunction

    function automatic logic [ID_W-1:0] ring_inc(input logic [ID_W-1:0] p);
        return (p == ID_W'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ID_W-1:0] ring_dec(input logic [ID_W-1:0] p);
        return (p == '0) ? ID_W'(SLOTS - 1) : p - 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] byte_addr(input logic [ID_W-1:0] id,
                                                    input logic [LEN_W-1:0] idx);
        return ADDR_W'(id) * ADDR_W'(MSG_BYTES) + ADDR_W'(idx);
    endfunction

endpackage

FILE: src/ps2_device_tx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_device_tx_queue
// Send queue of a PS/2 device-side transceiver with slot free list,
// send-order ring, priority insert, pause/resume and line word handling.
// ----------------------------------------------------------------------------
// Operation: one transaction at a time under a small sequencer. A message
// byte is stored in ST_BYTE; the final byte adds ST_STAT for the status result.
// Clear moves one ring entry per cycle back to the free ring until the queue
// is empty. A loop transaction that dispatches nothing handles its line word in
// ST_LOOP. A dispatching loop transaction runs ST_RD then ST_TX for each byte (byte
// store read, then the shared parity unit forms the frame), then returns to ST_LOOP.
// Every result waits in the output register while out_stall is high.
module ps2_device_tx_queue
    import ps2q_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        line_valid,
    input  logic [9:0]  line_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [10:0] tx_frame,
    output logic [9:0]  rx_value,
    output logic        parity_ok,
    output logic        accepted,
    output logic        last
);

    // sequencer and captured transaction
    state_t           state_reg, state_next;
    logic [2:0]       func_reg, func_next;
    logic [7:0]       byte_reg, byte_next;
    logic             lastb_reg, lastb_next;
    logic             lv_reg, lv_next;
    logic [9:0]       word_reg, word_next;

    // queue state
    logic [ID_W-1:0]  order_ring_reg [SLOTS];
    logic [ID_W-1:0]  order_ring_next [SLOTS];
    logic [ID_W-1:0]  free_ring_reg [SLOTS];
    logic [ID_W-1:0]  free_ring_next [SLOTS];
    logic [LEN_W-1:0] slot_len_reg [SLOTS];
    logic [LEN_W-1:0] slot_len_next [SLOTS];
    logic [LEN_W-1:0] slot_sent_reg [SLOTS];
    logic [LEN_W-1:0] slot_sent_next [SLOTS];
    logic [ID_W-1:0]  order_head_reg, order_head_next;
    logic [CNT_W-1:0] order_count_reg, order_count_next;
    logic [ID_W-1:0]  free_head_reg, free_head_next;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic             in_flight_reg, in_flight_next;
    logic             paused_reg, paused_next;

    // message under construction
    logic             build_open_reg, build_open_next;
    logic             build_ok_reg, build_ok_next;
    logic [ID_W-1:0]  build_slot_reg, build_slot_next;
    logic [LEN_W-1:0] build_index_reg, build_index_next;
    logic             stat_acc_reg, stat_acc_next;

    // dispatch walk
    logic [ID_W-1:0]  disp_id_reg, disp_id_next;
    logic [LEN_W-1:0] disp_len_reg, disp_len_next;
    logic [LEN_W-1:0] disp_cnt_reg, disp_cnt_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [10:0]      frame_reg, frame_next;
    logic [9:0]       rx_reg, rx_next;
    logic             pok_reg, pok_next;
    logic             acc_reg, acc_next;
    logic             last_reg, last_next;

    // byte store and parity unit
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;
    logic [7:0]        par_in;
    logic              par_odd;

    logic             in_accept;
    logic             out_free;
    logic             line_rx;
    logic             eff_ok;
    logic [ID_W-1:0]  eff_slot;
    logic [ID_W-1:0]  head_id;
    logic [ID_W-1:0]  free_tail;
    logic [LEN_W-1:0] eff_idx;
    logic [LEN_W-1:0] sent_inc;
    logic [LEN_W-1:0] cnt_inc;

    ps2q_byte_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one parity unit serves both the frame builder and the rx check
    assign par_in = (state_reg == ST_TX) ? ram_rdata : word_reg[7:0];

    ps2q_parity u_parity (
        .val (par_in),
        .odd (par_odd)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // a line word other than done/fail/zero produces a received-word result
    assign line_rx = lv_reg && (word_reg != LINE_DONE) && (word_reg != LINE_FAIL)
                     && (word_reg != LINE_NONE);

    assign eff_ok    = build_open_reg ? build_ok_reg : (free_count_reg != '0);
    assign eff_slot  = build_open_reg ? build_slot_reg : free_ring_reg[free_head_reg];
    assign eff_idx   = build_open_reg ? build_index_reg : '0;
    assign head_id   = order_ring_reg[order_head_reg];
    assign free_tail = ring_add(free_head_reg, free_count_reg);
    assign sent_inc  = slot_sent_reg[head_id] + 1'b1;
    assign cnt_inc   = disp_cnt_reg + 1'b1;

    assign ram_we    = (state_reg == ST_BYTE) && eff_ok
                       && (eff_idx < LEN_W'(MSG_BYTES));
    assign ram_waddr = byte_addr(eff_slot, eff_idx);
    assign ram_re    = (state_reg == ST_RD);
    assign ram_raddr = byte_addr(disp_id_reg, disp_cnt_reg);

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        byte_next        = byte_reg;
        lastb_next       = lastb_reg;
        lv_next          = lv_reg;
        word_next        = word_reg;
        order_ring_next  = order_ring_reg;
        free_ring_next   = free_ring_reg;
        slot_len_next    = slot_len_reg;
        slot_sent_next   = slot_sent_reg;
        order_head_next  = order_head_reg;
        order_count_next = order_count_reg;
        free_head_next   = free_head_reg;
        free_count_next  = free_count_reg;
        in_flight_next   = in_flight_reg;
        paused_next      = paused_reg;
        build_open_next  = build_open_reg;
        build_ok_next    = build_ok_reg;
        build_slot_next  = build_slot_reg;
        build_index_next = build_index_reg;
        stat_acc_next    = stat_acc_reg;
        disp_id_next     = disp_id_reg;
        disp_len_next    = disp_len_reg;
        disp_cnt_next    = disp_cnt_reg;
        out_valid_next   = out_valid_reg && out_stall;
        kind_next        = kind_reg;
        frame_next       = frame_reg;
        rx_next          = rx_reg;
        pok_next         = pok_reg;
        acc_next         = acc_reg;
        last_next        = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    func_next  = func;
                    byte_next  = data_byte;
                    lastb_next = last_byte;
                    lv_next    = line_valid;
                    word_next  = line_word;
                    case (func)
                        FUNC_NORMAL, FUNC_PRIO: state_next = ST_BYTE;
                        FUNC_CLEAR:             state_next = ST_CLEAR;
                        FUNC_RESUME:            paused_next = 1'b0;
                        FUNC_LOOP:              state_next = ST_LOOP;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end

            ST_BYTE:
            begin
                // slot is chosen from the free head when the message opens; the free head advances on the final byte
                build_open_next  = 1'b1;
                build_ok_next    = eff_ok;
                build_slot_next  = eff_ok ? eff_slot : '0;
                build_index_next = ram_we ? eff_idx + 1'b1 : eff_idx;
                state_next       = ST_IDLE;
                if (lastb_reg)
                begin
                    stat_acc_next = eff_ok;
                    if (eff_ok)
                    begin
                        free_head_next  = ring_inc(free_head_reg);
                        free_count_next = free_count_reg - 1'b1;
                        slot_len_next[eff_slot]  = ram_we ? eff_idx + 1'b1 : eff_idx;
                        slot_sent_next[eff_slot] = '0;
                        if (func_reg == FUNC_PRIO)
                        begin
                            order_head_next = ring_dec(order_head_reg);
                            order_ring_next[ring_dec(order_head_reg)] = eff_slot;
                        end
                        else
                        begin
                            order_ring_next[ring_add(order_head_reg, order_count_reg)]
                                = eff_slot;
                        end
                        order_count_next = order_count_reg + 1'b1;
                    end
                    build_open_next  = 1'b0;
                    build_ok_next    = 1'b0;
                    build_slot_next  = '0;
                    build_index_next = '0;
                    state_next       = ST_STAT;
                end
            end

            ST_STAT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_STAT;
                    frame_next     = '0;
                    rx_next        = '0;
                    pok_next       = 1'b0;
                    acc_next       = stat_acc_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_CLEAR:
            begin
                // move one queued id back to the free ring per cycle
                if (order_count_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    free_ring_next[free_tail] = head_id;
                    free_count_next  = free_count_reg + 1'b1;
                    order_head_next  = ring_inc(order_head_reg);
                    order_count_next = order_count_reg - 1'b1;
                end
            end

            ST_LOOP:
            begin
                disp_cnt_next = '0;
                if (!paused_reg && !in_flight_reg && (order_count_reg != '0))
                begin
                    in_flight_next = 1'b1;
                    disp_id_next   = head_id;
                    disp_len_next  = slot_len_reg[head_id];
                    state_next     = ST_RD;
                end
                else
                begin
                    // line word handling
                    state_next = ST_IDLE;
                    if (lv_reg && (word_reg == LINE_DONE) && (order_count_reg != '0))
                    begin
                        slot_sent_next[head_id] = sent_inc;
                        if (sent_inc == slot_len_reg[head_id])
                        begin
                            free_ring_next[free_tail] = head_id;
                            free_count_next  = free_count_reg + 1'b1;
                            order_head_next  = ring_inc(order_head_reg);
                            order_count_next = order_count_reg - 1'b1;
                            in_flight_next   = 1'b0;
                        end
                    end
                    else if (lv_reg && (word_reg == LINE_FAIL) && (order_count_reg != '0))
                    begin
                        slot_sent_next[head_id] = '0;
                        in_flight_next = 1'b0;
                        paused_next    = 1'b1;
                    end
                    else if (line_rx)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_RX;
                            frame_next     = '0;
                            rx_next        = word_reg;
                            pok_next       = (par_odd == word_reg[8]);
                            acc_next       = 1'b0;
                            last_next      = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_LOOP;
                        end
                    end
                end
            end

            ST_RD:
            begin
                state_next = ST_TX;
            end

            ST_TX:
            begin
                if (out_free)
                begin
                    // inverted frame: stop 0, parity ^d, data ~d, start 1
                    out_valid_next = 1'b1;
                    kind_next      = KIND_TX;
                    frame_next     = {1'b0, ~par_odd, ~ram_rdata, 1'b1};
                    rx_next        = '0;
                    pok_next       = 1'b0;
                    acc_next       = 1'b0;
                    last_next      = (cnt_inc == disp_len_reg) && !line_rx;
                    disp_cnt_next  = cnt_inc;
                    // after the last byte, fall back to ST_LOOP for the line word;
                    // in_flight is now set so no second dispatch happens
                    state_next     = (cnt_inc == disp_len_reg) ? ST_LOOP : ST_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            order_head_reg  <= '0;
            order_count_reg <= '0;
            free_head_reg   <= '0;
            free_count_reg  <= CNT_W'(SLOTS);
            in_flight_reg   <= 1'b0;
            paused_reg      <= 1'b0;
            build_open_reg  <= 1'b0;
            build_ok_reg    <= 1'b0;
            build_slot_reg  <= '0;
            build_index_reg <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                free_ring_reg[i] <= ID_W'(i);
            end
        end
        else
        begin
            state_reg       <= state_next;
            order_head_reg  <= order_head_next;
            order_count_reg <= order_count_next;
            free_head_reg   <= free_head_next;
            free_count_reg  <= free_count_next;
            in_flight_reg   <= in_flight_next;
            paused_reg      <= paused_next;
            build_open_reg  <= build_open_next;
            build_ok_reg    <= build_ok_next;
            build_slot_reg  <= build_slot_next;
            build_index_reg <= build_index_next;
            out_valid_reg   <= out_valid_next;
            free_ring_reg   <= free_ring_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        byte_reg       <= byte_next;
        lastb_reg      <= lastb_next;
        lv_reg         <= lv_next;
        word_reg       <= word_next;
        order_ring_reg <= order_ring_next;
        slot_len_reg   <= slot_len_next;
        slot_sent_reg  <= slot_sent_next;
        stat_acc_reg   <= stat_acc_next;
        disp_id_reg    <= disp_id_next;
        disp_len_reg   <= disp_len_next;
        disp_cnt_reg   <= disp_cnt_next;
        kind_reg       <= kind_next;
        frame_reg      <= frame_next;
        rx_reg         <= rx_next;
        pok_reg        <= pok_next;
        acc_reg        <= acc_next;
        last_reg       <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign tx_frame  = frame_reg;
    assign rx_value  = rx_reg;
    assign parity_ok = pok_reg;
    assign accepted  = acc_reg;
    assign last      = last_reg;

endmodule

FILE: src/ps2q_byte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2q_byte_ram
// Message byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ps2q_byte_ram
    import ps2q_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/ps2q_parity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2q_parity
// Shared odd-parity unit, used for outgoing frames and incoming words.
// ----------------------------------------------------------------------------
module ps2q_parity
    import ps2q_pkg::*;
(
    input  logic [7:0] val,
    output logic       odd
);

    assign odd = ~^val;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the PS/2 device send queue against a behavioral queue model:
// directed corner cases, then random message traffic with line words.
// ----------------------------------------------------------------------------

// Holds the frames, line words and status results that the queue should emit.
class ps2q_scoreboard;
    logic [34:0] pending[$];   // {kind, frame, rx, pok, acc, last}
    int errors;
    int checked;

    // Records the results caused by one accepted transaction.
    function void note_input(logic [34:0] res[$]);
        foreach (res[i]) pending.push_back(res[i]);
    endfunction

    // Compares one result with the oldest pending one.
    task check_result(logic [1:0] k, logic [10:0] f, logic [9:0] r,
                      logic p, logic a, logic l);
        logic [34:0] e;
        if (pending.size() == 0)
        begin
            report("result with nothing pending");
            return;
        end
        e = pending.pop_front();
        checked++;
        if ({k, f, r, p, a, l} !== e[25:0])
            report($sformatf("got k%0d f%03h r%03h p%0d a%0d l%0d exp %07h",
                             k, f, r, p, a, l, e[25:0]));
    endtask

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask
endclass

module testbench;
    import ps2q_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  func;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        line_valid;
    logic [9:0]  line_word;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [10:0] tx_frame;
    logic [9:0]  rx_value;
    logic        parity_ok;
    logic        accepted;
    logic        last;

    ps2_device_tx_queue dut (.*);

    ps2q_scoreboard sb;

    // Queue model state.
    logic [7:0] m_bytes[SLOTS*MSG_BYTES];
    int  m_len[SLOTS];
    int  m_sent[SLOTS];
    int  m_order[SLOTS];
    int  m_free[SLOTS];
    int  o_head, o_cnt, f_head, f_cnt;
    bit  m_flight, m_paused, b_open, b_ok;
    int  b_slot, b_idx;

    bit  quiet;          // no idling in the final stretch
    int  idle_cnt;
    int  n_frames, n_rx, n_stat;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic odd_par(logic [7:0] v);
        return ~^v;
    endfunction

    // 26-bit packed result: kind, frame, rx, pok, acc, last.
    function automatic logic [34:0] pack_res(logic [1:0] k, logic [10:0] f,
                                             logic [9:0] r, logic p, logic a);
        return {9'd0, k, f, r, p, a, 1'b0};
    endfunction

    // Advances the queue model by one transaction and returns its results.
    function automatic void predict_queue(logic [2:0] fn, logic [7:0] d, logic lb,
                                          logic lv, logic [9:0] w,
                                          ref logic [34:0] res[$]);
        int id;
        res.delete();
        if (fn == FUNC_NORMAL || fn == FUNC_PRIO)
        begin
            if (!b_open)
            begin
                b_open = 1;
                b_ok = f_cnt > 0;
                b_slot = b_ok ? m_free[f_head] : 0;
                b_idx = 0;
            end
            if (b_ok && b_idx < MSG_BYTES)
            begin
                m_bytes[b_slot*MSG_BYTES + b_idx] = d;
                b_idx++;
            end
            if (lb)
            begin
                res.push_back(pack_res(KIND_STAT, '0, '0, 1'b0, b_ok));
                if (b_ok && f_cnt > 0)
                begin
                    id = m_free[f_head];
                    f_head = (f_head + 1) % SLOTS;
                    f_cnt--;
                    m_len[id] = b_idx;
                    m_sent[id] = 0;
                    if (o_cnt < SLOTS)
                    begin
                        if (fn == FUNC_PRIO)
                        begin
                            o_head = (o_head + SLOTS - 1) % SLOTS;
                            m_order[o_head] = id;
                        end
                        else
                            m_order[(o_head + o_cnt) % SLOTS] = id;
                        o_cnt++;
                    end
                end
                b_open = 0;
                b_ok = 0;
                b_idx = 0;
                n_stat++;
            end
        end
        else if (fn == FUNC_CLEAR)
        begin
            while (o_cnt > 0)
            begin
                id = m_order[o_head];
                o_head = (o_head + 1) % SLOTS;
                o_cnt--;
                if (f_cnt < SLOTS)
                begin
                    m_free[(f_head + f_cnt) % SLOTS] = id;
                    f_cnt++;
                end
            end
        end
        else if (fn == FUNC_RESUME)
            m_paused = 0;
        else if (fn == FUNC_LOOP)
        begin
            if (!m_paused && !m_flight && o_cnt > 0)
            begin
                logic [7:0] b;
                id = m_order[o_head];
                m_flight = 1;
                for (int i = 0; i < m_len[id] && i < MSG_BYTES; i++)
                begin
                    b = m_bytes[id*MSG_BYTES + i];
                    res.push_back(pack_res(KIND_TX,
                        {1'b1, odd_par(b), b, 1'b0} ^ 11'h7FF, '0, 1'b0, 1'b0));
                    n_frames++;
                end
            end
            if (lv)
            begin
                if (w == LINE_DONE)
                begin
                    if (o_cnt > 0)
                    begin
                        id = m_order[o_head];
                        m_sent[id] = (m_sent[id] + 1) % 256;
                        if (m_sent[id] == m_len[id])
                        begin
                            o_head = (o_head + 1) % SLOTS;
                            o_cnt--;
                            if (f_cnt < SLOTS)
                            begin
                                m_free[(f_head + f_cnt) % SLOTS] = id;
                                f_cnt++;
                            end
                            m_flight = 0;
                        end
                    end
                end
                else if (w == LINE_FAIL)
                begin
                    if (o_cnt > 0)
                    begin
                        m_sent[m_order[o_head]] = 0;
                        m_flight = 0;
                        m_paused = 1;
                    end
                end
                else if (w != LINE_NONE)
                begin
                    res.push_back(pack_res(KIND_RX, '0, w,
                                           odd_par(w[7:0]) == w[8], 1'b0));
                    n_rx++;
                end
            end
        end
        if (res.size() > 0)
            res[res.size()-1][0] = 1'b1;
    endfunction

    // Sends one transaction; the model is advanced when it is accepted.
    task automatic send_item(logic [2:0] fn, logic [7:0] d, logic lb,
                             logic lv, logic [9:0] w);
        logic [34:0] res[$];
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= fn;
        data_byte  <= d;
        last_byte  <= lb;
        line_valid <= lv;
        line_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_queue(fn, d, lb, lv, w, res);
        sb.note_input(res);
    endtask

    // Full message of n bytes; with prio set the final byte carries the priority mark.
    task automatic send_msg(int n, bit prio);
        for (int i = 0; i < n; i++)
            send_item((i == n-1 && prio) ? FUNC_PRIO :
                      (($urandom_range(0, 1) == 0) ? FUNC_NORMAL : FUNC_PRIO),
                      8'($urandom), i == n-1, 1'($urandom), 10'($urandom));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Random line word biased toward done and fail.
    function automatic logic [9:0] pick_word();
        case ($urandom_range(0, 5))
            0, 1, 2: return LINE_DONE;
            3:       return LINE_FAIL;
            4:       return LINE_NONE;
            default: return 10'($urandom);
        endcase
    endfunction

    // Result side: random stall bursts, checks every accepted result.
    initial
    begin
        int burst;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(kind, tx_frame, rx_value, parity_ok, accepted, last);
            if (burst > 0)
                burst--;
            else if (!quiet && $urandom_range(0, 7) == 0)
                burst = $urandom_range(1, 14);
            out_stall <= (burst > 0);
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    initial
    begin
        idle_cnt = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cnt = 0;
            else if (++idle_cnt > 5000)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_LOOP;
        data_byte = '0;
        last_byte = 1'b0;
        line_valid = 1'b0;
        line_word = '0;
        quiet = 0;
        o_head = 0; o_cnt = 0; f_head = 0; f_cnt = SLOTS;
        for (int i = 0; i < SLOTS; i++) m_free[i] = i;
        m_flight = 0; m_paused = 0; b_open = 0; b_ok = 0; b_slot = 0; b_idx = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme bytes, long message, priority, fail, resume, rx parity.
        send_item(FUNC_NORMAL, 8'h00, 1'b0, 1'b0, LINE_NONE);
        send_item(FUNC_NORMAL, 8'hFF, 1'b1, 1'b0, LINE_NONE);
        send_item(FUNC_LOOP, 8'h00, 1'b0, 1'b1, 10'h155);
        send_item(FUNC_LOOP, 8'h00, 1'b0, 1'b1, 10'h055);
        for (int i = 0; i < 10; i++)            // saturates at MSG_BYTES
            send_item(FUNC_NORMAL, 8'hA5 ^ 8'(i), i == 9, 1'b0, LINE_NONE);
        send_item(FUNC_PRIO, 8'h5A, 1'b1, 1'b0, LINE_NONE);   // priority while in flight
        send_item(FUNC_LOOP, 8'h00, 1'b0, 1'b1, LINE_FAIL);
        send_item(FUNC_LOOP, 8'h00, 1'b0, 1'b1, LINE_DONE); // done counts while paused
        send_item(FUNC_RESUME, 8'h00, 1'b0, 1'b0, LINE_NONE);
        send_item(FUNC_LOOP, 8'h00, 1'b0, 1'b0, LINE_NONE);
        send_item(FUNC_LOOP, 8'h00, 1'b0, 1'b1, LINE_DONE);
        send_item(FUNC_CLEAR, 8'h00, 1'b0, 1'b0, LINE_NONE);
        send_item(3'd5, 8'h33, 1'b1, 1'b1, 10'h3FF);  // unused codes ignored
        send_item(3'd7, 8'hCC, 1'b0, 1'b1, 10'h2AA);
        send_item(FUNC_LOOP, 8'h00, 1'b0, 1'b1, LINE_DONE); // done on empty queue
        send_item(FUNC_LOOP, 8'h00, 1'b0, 1'b1, LINE_FAIL); // fail on empty queue
        drain_results();                        // sender waits for everything

        // Fill every slot, then one more message that finds no free slot.
        for (int m = 0; m <= SLOTS; m++)
            send_msg(1, 0);
        send_item(FUNC_CLEAR, 8'h00, 1'b0, 1'b0, LINE_NONE);

        // Random traffic: mostly loop items and full messages, plus resumes, clears and random codes.
        for (int k = 0; k < 170; k++)
        begin
            if (k == 136) quiet = 1;
            case ($urandom_range(0, 9))
                0, 1, 2: send_msg($urandom_range(1, 3) == 3 ? $urandom_range(1, 10)
                                  : $urandom_range(1, 3), $urandom_range(0, 3) == 0);
                3, 4, 5, 6: send_item(FUNC_LOOP, 8'($urandom), 1'($urandom),
                                      $urandom_range(0, 5) != 0, pick_word());
                7: send_item(FUNC_RESUME, 8'($urandom), 1'($urandom), 1'($urandom),
                             10'($urandom));
                8: send_item($urandom_range(0, 9) == 0 ? FUNC_CLEAR : FUNC_LOOP,
                             8'($urandom), 1'($urandom), 1'b1, 10'($urandom));
                default: send_item(3'($urandom_range(0, 7)), 8'($urandom),
                                   1'($urandom), 1'($urandom), 10'($urandom));
            endcase
        end

        in_valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d frames, %0d line words, %0d enqueue results",
                 n_frames, n_rx, n_stat);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
